@@ hw/rtl/gtsf_pkg.sv @@
// Shared constants, codes and types for the silence trim block.
package gtsf_pkg;

   localparam int POSITION_BITS  = 32;
   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_CHANNELS   = 8;

   localparam int GATE_BITS      = 15;
   localparam int CHAN_BITS      = 4;
   localparam int SPLICE_BITS    = 15;
   localparam int BACKTRACK_BITS = 20;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;

   // splice length in samples: splice frames times channels
   localparam int SPAN_BITS      = SPLICE_BITS + CHAN_BITS;
   // a frame offset inside a ramp stays below the longest span
   localparam int FRAME_BITS     = $clog2(((2 ** SPLICE_BITS) - 1) * MAX_CHANNELS);
   // magnitude times a ramp factor stays below 2^(SAMPLE_BITS-1+SPLICE_BITS)
   localparam int GAIN_BITS      = SAMPLE_BITS - 1 + SPLICE_BITS;
   localparam int PROD_BITS      = SAMPLE_BITS + SPLICE_BITS;
   localparam int DIV_COUNT_BITS = $clog2(POSITION_BITS + 1);

   localparam logic [CHAN_BITS-1:0]   CHANNELS_RESET = CHAN_BITS'(1);
   localparam logic [SPLICE_BITS-1:0] SPLICE_RESET   = SPLICE_BITS'(720);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_GATE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_GATE   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNELS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPLICE     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BACKTRACK  = 3'd4;

   localparam logic OP_MEASURE  = 1'b0;
   localparam logic OP_EMIT     = 1'b1;
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ALL_BELOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_REMOVED   = 2'd2;

   typedef struct packed {
      logic                      start;
      logic [DIV_COUNT_BITS-1:0] steps;
      logic [POSITION_BITS-1:0]  dividend;
      logic [SPLICE_BITS-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic [POSITION_BITS-1:0] quotient;
      logic [SPLICE_BITS-1:0]   remainder;
   } div_rsp_type;

endpackage

@@ hw/rtl/gtsf_div.sv @@
// Restoring divider, one quotient bit per cycle, dividend left-aligned by the caller.
module gtsf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gtsf_pkg::div_req_type req,
   output gtsf_pkg::div_rsp_type rsp
);

   logic [gtsf_pkg::SPLICE_BITS-1:0]    rem_ff, rem_in;
   logic [gtsf_pkg::SPLICE_BITS-1:0]    divisor_ff, divisor_in;
   logic [gtsf_pkg::POSITION_BITS-1:0]  quo_ff, quo_in;
   logic [gtsf_pkg::DIV_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [gtsf_pkg::SPLICE_BITS:0]      trial;
   logic [gtsf_pkg::SPLICE_BITS:0]      trial_sub;
   logic                                fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[gtsf_pkg::POSITION_BITS-1]};
      trial_sub  = trial - {1'b0, divisor_ff};
      fits       = (trial >= {1'b0, divisor_ff});
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (req.start) begin
         rem_in     = '0;
         quo_in     = req.dividend;
         cnt_in     = req.steps;
         divisor_in = req.divisor;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[gtsf_pkg::SPLICE_BITS-1:0]
                       : trial[gtsf_pkg::SPLICE_BITS-1:0];
         quo_in = {quo_ff[gtsf_pkg::POSITION_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == gtsf_pkg::DIV_COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ hw/rtl/gate_trim_with_splice_fades.sv @@
// Measure pass: one sample per cycle; the last sample reports after two remainders by the channel count.
// Emit pass: a sample outside the kept region gives no result; inside it, fades use the shared
//   restoring divider (18-bit frame number, 30-bit ramp gain quotients, up to two of each).
// A finished result waits in the output register while the next transfer is taken.
// Synchronous reset clears pass state, the region and the output, and loads register defaults;
//   no clearing pass is needed.
module gate_trim_with_splice_fades (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_opcode,
   input  logic signed [gtsf_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                                  req_is_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_kind,
   output logic signed [gtsf_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [gtsf_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [31:0]                           rsp_start_position,
   output logic [31:0]                           rsp_end_position,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gtsf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gtsf_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int PB = gtsf_pkg::POSITION_BITS;
   localparam int SB = gtsf_pkg::SAMPLE_BITS;
   localparam int LB = gtsf_pkg::SPLICE_BITS;
   localparam int CB = gtsf_pkg::CHAN_BITS;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MREM1   = 4'd1;
   localparam logic [3:0] S_MREM2   = 4'd2;
   localparam logic [3:0] S_MRPT    = 4'd3;
   localparam logic [3:0] S_EMIT    = 4'd4;
   localparam logic [3:0] S_FI_CHK  = 4'd5;
   localparam logic [3:0] S_FI_DIV  = 4'd6;
   localparam logic [3:0] S_FI_SCL  = 4'd7;
   localparam logic [3:0] S_FO_FROM = 4'd8;
   localparam logic [3:0] S_FO_CHK  = 4'd9;
   localparam logic [3:0] S_FO_DIV  = 4'd10;
   localparam logic [3:0] S_FO_SCL  = 4'd11;
   localparam logic [3:0] S_OUT     = 4'd12;

   // configuration
   logic [gtsf_pkg::GATE_BITS-1:0]      start_gate_ff, start_gate_in;
   logic [gtsf_pkg::GATE_BITS-1:0]      end_gate_ff, end_gate_in;
   logic [CB-1:0]                       channels_ff, channels_in;
   logic [LB-1:0]                       splice_ff, splice_in;
   logic [gtsf_pkg::BACKTRACK_BITS-1:0] backtrack_ff, backtrack_in;

   // pass state
   logic [3:0]    state_ff, state_in;
   logic [PB-1:0] position_ff, position_in;
   logic [PB-1:0] first_hit_ff, first_hit_in;
   logic [PB-1:0] last_hit_ff, last_hit_in;
   logic          found_first_ff, found_first_in;
   logic          found_last_ff, found_last_in;
   logic [PB-1:0] region_start_ff, region_start_in;
   logic [PB-1:0] region_end_ff, region_end_in;
   logic          fade_in_on_ff, fade_in_on_in;

   // work registers
   logic [PB-1:0] pos_cur_ff, pos_cur_in;
   logic          neg_ff, neg_in;
   logic [SB-1:0] mag_ff, mag_in;
   logic [PB-1:0] aligned_ff, aligned_in;
   logic [PB-1:0] start_cand_ff, start_cand_in;
   logic [PB-1:0] end_cand_ff, end_cand_in;
   logic [PB-1:0] fade_from_ff, fade_from_in;
   logic          res_kind_ff, res_kind_in;
   logic [gtsf_pkg::STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [PB-1:0] res_start_ff, res_start_in;
   logic [PB-1:0] res_end_ff, res_end_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [SB-1:0] rsp_sample_ff, rsp_sample_in;
   logic [gtsf_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_start_ff, rsp_start_in;
   logic [31:0]   rsp_end_ff, rsp_end_in;

   // helpers
   logic [CB-1:0]                  ch_eff;
   logic [LB-1:0]                  sp_eff;
   logic [gtsf_pkg::SPAN_BITS-1:0] span;
   logic [PB-1:0]                  span_pos;
   logic [SB-1:0]                  req_raw;
   logic [SB-1:0]                  req_mag;
   logic                           req_xfer;
   logic                           hit_first;
   logic                           hit_last;
   logic [PB-1:0]                  pos_next;
   logic [PB-1:0]                  in_diff;
   logic [PB-1:0]                  out_diff;
   logic [LB-1:0]                  gain_factor;
   logic [gtsf_pkg::PROD_BITS-1:0] gain_prod;
   logic [PB-1:0]                  frame_dividend;
   logic [PB-1:0]                  gain_dividend;
   logic [PB-1:0]                  rem_pos;
   logic                           removed;

   gtsf_pkg::div_req_type div_req;
   gtsf_pkg::div_rsp_type div_rsp;

   gtsf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      if (channels_ff == '0) begin
         ch_eff = CB'(1);
      end else if (channels_ff > CB'(gtsf_pkg::MAX_CHANNELS)) begin
         ch_eff = CB'(gtsf_pkg::MAX_CHANNELS);
      end else begin
         ch_eff = channels_ff;
      end
      sp_eff   = (splice_ff == '0) ? LB'(1) : splice_ff;
      span     = gtsf_pkg::SPAN_BITS'(sp_eff) * gtsf_pkg::SPAN_BITS'(ch_eff);
      span_pos = PB'(span);

      req_raw   = req_sample_in;
      req_mag   = req_raw[SB-1] ? (~req_raw + 1'b1) : req_raw;
      req_xfer  = req_valid && req_ready;
      hit_first = !found_first_ff && (req_mag > {1'b0, start_gate_ff});
      hit_last  = req_mag > {1'b0, end_gate_ff};
      if (req_is_last) begin
         pos_next = '0;
      end else if (position_ff != '1) begin
         pos_next = position_ff + 1'b1;
      end else begin
         pos_next = position_ff;
      end

      in_diff  = pos_cur_ff - region_start_ff;
      out_diff = pos_cur_ff - fade_from_ff;
      rem_pos  = PB'(div_rsp.remainder);
      removed  = (end_cand_ff == start_cand_ff) || (end_cand_ff <= span_pos);

      // fade-out factor counts down from splice-1
      gain_factor = (state_ff == S_FO_DIV)
                    ? (sp_eff - LB'(1) - div_rsp.quotient[LB-1:0])
                    : div_rsp.quotient[LB-1:0];
      gain_prod   = gtsf_pkg::PROD_BITS'(mag_ff) * gtsf_pkg::PROD_BITS'(gain_factor);
      gain_dividend  = {gain_prod[gtsf_pkg::GAIN_BITS-1:0],
                        {(PB - gtsf_pkg::GAIN_BITS){1'b0}}};
      frame_dividend = state_ff == S_FI_CHK
                       ? {in_diff[gtsf_pkg::FRAME_BITS-1:0],
                          {(PB - gtsf_pkg::FRAME_BITS){1'b0}}}
                       : {out_diff[gtsf_pkg::FRAME_BITS-1:0],
                          {(PB - gtsf_pkg::FRAME_BITS){1'b0}}};
   end

   always_comb begin
      start_gate_in   = start_gate_ff;
      end_gate_in     = end_gate_ff;
      channels_in     = channels_ff;
      splice_in       = splice_ff;
      backtrack_in    = backtrack_ff;
      state_in        = state_ff;
      position_in     = position_ff;
      first_hit_in    = first_hit_ff;
      last_hit_in     = last_hit_ff;
      found_first_in  = found_first_ff;
      found_last_in   = found_last_ff;
      region_start_in = region_start_ff;
      region_end_in   = region_end_ff;
      fade_in_on_in   = fade_in_on_ff;
      pos_cur_in      = pos_cur_ff;
      neg_in          = neg_ff;
      mag_in          = mag_ff;
      aligned_in      = aligned_ff;
      start_cand_in   = start_cand_ff;
      end_cand_in     = end_cand_ff;
      fade_from_in    = fade_from_ff;
      res_kind_in     = res_kind_ff;
      res_status_in   = res_status_ff;
      res_start_in    = res_start_ff;
      res_end_in      = res_end_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_end_in      = rsp_end_ff;
      div_req         = '0;

      if (csr_valid) begin
         case (csr_index)
            gtsf_pkg::REG_START_GATE: start_gate_in = csr_data[gtsf_pkg::GATE_BITS-1:0];
            gtsf_pkg::REG_END_GATE:   end_gate_in   = csr_data[gtsf_pkg::GATE_BITS-1:0];
            gtsf_pkg::REG_CHANNELS:   channels_in   = csr_data[CB-1:0];
            gtsf_pkg::REG_SPLICE:     splice_in     = csr_data[LB-1:0];
            gtsf_pkg::REG_BACKTRACK:  backtrack_in  = csr_data[gtsf_pkg::BACKTRACK_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               position_in = pos_next;
               if (req_opcode == gtsf_pkg::OP_MEASURE) begin
                  if (hit_first) begin
                     first_hit_in   = position_ff;
                     found_first_in = 1'b1;
                  end
                  if (hit_last) begin
                     last_hit_in   = position_ff;
                     found_last_in = 1'b1;
                  end
                  if (req_is_last) begin
                     found_first_in = 1'b0;
                     found_last_in  = 1'b0;
                     res_kind_in    = gtsf_pkg::KIND_REPORT;
                     if ((found_first_ff || hit_first) && (found_last_ff || hit_last)) begin
                        div_req.start    = 1'b1;
                        div_req.steps    = gtsf_pkg::DIV_COUNT_BITS'(PB);
                        div_req.dividend = hit_first ? position_ff : first_hit_ff;
                        div_req.divisor  = LB'(ch_eff);
                        state_in         = S_MREM1;
                     end else begin
                        res_status_in   = gtsf_pkg::STATUS_ALL_BELOW;
                        res_start_in    = '0;
                        res_end_in      = '0;
                        region_start_in = '0;
                        region_end_in   = '0;
                        fade_in_on_in   = 1'b0;
                        state_in        = S_OUT;
                     end
                  end
               end else begin
                  pos_cur_in    = position_ff;
                  neg_in        = req_raw[SB-1];
                  mag_in        = req_mag;
                  res_kind_in   = gtsf_pkg::KIND_SAMPLE;
                  res_status_in = gtsf_pkg::STATUS_OK;
                  res_start_in  = '0;
                  res_end_in    = '0;
                  state_in      = S_EMIT;
               end
            end
         end
         S_MREM1: begin
            if (div_rsp.done) begin
               aligned_in       = first_hit_ff - rem_pos;
               div_req.start    = 1'b1;
               div_req.steps    = gtsf_pkg::DIV_COUNT_BITS'(PB);
               div_req.dividend = last_hit_ff;
               div_req.divisor  = LB'(ch_eff);
               state_in         = S_MREM2;
            end
         end
         S_MREM2: begin
            if (div_rsp.done) begin
               end_cand_in   = last_hit_ff - rem_pos;
               start_cand_in = (aligned_ff > PB'(backtrack_ff))
                               ? aligned_ff - PB'(backtrack_ff) : '0;
               state_in      = S_MRPT;
            end
         end
         S_MRPT: begin
            if (removed) begin
               res_status_in   = gtsf_pkg::STATUS_REMOVED;
               res_start_in    = '0;
               res_end_in      = '0;
               region_start_in = '0;
               region_end_in   = '0;
               fade_in_on_in   = 1'b0;
            end else begin
               res_status_in   = gtsf_pkg::STATUS_OK;
               res_start_in    = start_cand_ff;
               res_end_in      = end_cand_ff;
               region_start_in = start_cand_ff;
               region_end_in   = end_cand_ff;
               fade_in_on_in   = start_cand_ff > span_pos;
            end
            state_in = S_OUT;
         end
         S_EMIT: begin
            if ((pos_cur_ff < region_start_ff) || (pos_cur_ff >= region_end_ff)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_FI_CHK;
            end
         end
         S_FI_CHK: begin
            // frame number below splice is the same as offset below one span
            if (fade_in_on_ff && (in_diff < span_pos)) begin
               div_req.start    = 1'b1;
               div_req.steps    = gtsf_pkg::DIV_COUNT_BITS'(gtsf_pkg::FRAME_BITS);
               div_req.dividend = frame_dividend;
               div_req.divisor  = LB'(ch_eff);
               state_in         = S_FI_DIV;
            end else begin
               state_in = S_FO_FROM;
            end
         end
         S_FI_DIV, S_FO_DIV: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.steps    = gtsf_pkg::DIV_COUNT_BITS'(gtsf_pkg::GAIN_BITS);
               div_req.dividend = gain_dividend;
               div_req.divisor  = sp_eff;
               state_in         = (state_ff == S_FI_DIV) ? S_FI_SCL : S_FO_SCL;
            end
         end
         S_FI_SCL, S_FO_SCL: begin
            if (div_rsp.done) begin
               mag_in   = div_rsp.quotient[SB-1:0];
               state_in = (state_ff == S_FI_SCL) ? S_FO_FROM : S_OUT;
            end
         end
         S_FO_FROM: begin
            fade_from_in = (region_end_ff >= span_pos) ? region_end_ff - span_pos : '0;
            state_in     = S_FO_CHK;
         end
         S_FO_CHK: begin
            if ((pos_cur_ff >= fade_from_ff) && (out_diff < span_pos)) begin
               div_req.start    = 1'b1;
               div_req.steps    = gtsf_pkg::DIV_COUNT_BITS'(gtsf_pkg::FRAME_BITS);
               div_req.dividend = frame_dividend;
               div_req.divisor  = LB'(ch_eff);
               state_in         = S_FO_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_sample_in = (res_kind_ff == gtsf_pkg::KIND_REPORT) ? '0
                               : (neg_ff ? (~mag_ff + 1'b1) : mag_ff);
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff[31:0];
               rsp_end_in    = res_end_ff[31:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_gate_ff   <= '0;
         end_gate_ff     <= '0;
         channels_ff     <= gtsf_pkg::CHANNELS_RESET;
         splice_ff       <= gtsf_pkg::SPLICE_RESET;
         backtrack_ff    <= '0;
         state_ff        <= S_IDLE;
         position_ff     <= '0;
         first_hit_ff    <= '0;
         last_hit_ff     <= '0;
         found_first_ff  <= 1'b0;
         found_last_ff   <= 1'b0;
         region_start_ff <= '0;
         region_end_ff   <= '0;
         fade_in_on_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         start_gate_ff   <= start_gate_in;
         end_gate_ff     <= end_gate_in;
         channels_ff     <= channels_in;
         splice_ff       <= splice_in;
         backtrack_ff    <= backtrack_in;
         state_ff        <= state_in;
         position_ff     <= position_in;
         first_hit_ff    <= first_hit_in;
         last_hit_ff     <= last_hit_in;
         found_first_ff  <= found_first_in;
         found_last_ff   <= found_last_in;
         region_start_ff <= region_start_in;
         region_end_ff   <= region_end_in;
         fade_in_on_ff   <= fade_in_on_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_cur_ff    <= pos_cur_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      aligned_ff    <= aligned_in;
      start_cand_ff <= start_cand_in;
      end_cand_ff   <= end_cand_in;
      fade_from_ff  <= fade_from_in;
      res_kind_ff   <= res_kind_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_end_ff    <= res_end_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_start_position = rsp_start_ff;
   assign rsp_end_position   = rsp_end_ff;

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_rsp.busy)
      else $error("divider busy while taking a new transfer");

   a_bad_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != gtsf_pkg::STATUS_OK))
      |-> ((rsp_start_position == '0) && (rsp_end_position == '0)))
      else $error("non-ok report carries positions");

   a_sample_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == gtsf_pkg::KIND_SAMPLE))
      |-> (rsp_status == gtsf_pkg::STATUS_OK))
      else $error("sample result with status set");

   a_hits_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == gtsf_pkg::OP_MEASURE) && req_is_last)
      |=> (!found_first_ff && !found_last_ff))
      else $error("hit flags survive end of measure pass");

endmodule
